// ----- hdl/xs_pkg.sv -----
package xs_pkg;

  localparam logic [63:0] SM_GAMMA   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL1    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL2    = 64'h94D049BB133111EB;
  localparam logic [63:0] RESET_SEED = 64'd42;

  // command queue between front and back, power-of-two depth
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int NWORDS = 4;
  localparam int WIW    = $clog2(NWORDS);
  localparam int BITS   = 64;
  localparam int BCW    = $clog2(BITS);

  typedef enum logic [1:0] {
    ACT_SEED  = 2'd0,
    ACT_RAW   = 2'd1,
    ACT_RANGE = 2'd2,
    ACT_NONE  = 2'd3
  } xs_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SM_ADD,
    ST_MUL,
    ST_STEP,
    ST_SCRAMBLE,
    ST_DIV,
    ST_DONE
  } xs_state_t;

  typedef struct packed {
    xs_action_t  action;
    logic [63:0] seed;
    logic [31:0] lo;
    logic [63:0] span;
    logic        span_zero;
  } xs_cmd_t;

endpackage

// ----- hdl/xs_front.sv -----
module xs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [63:0]       seed_value,
  input  logic signed [31:0] range_low,
  input  logic signed [31:0] range_high,
  output xs_pkg::xs_cmd_t   cmd,
  output logic              cmd_valid,
  input  logic              cmd_take
);

  xs_pkg::xs_cmd_t              q_r [xs_pkg::QDEPTH];
  logic [xs_pkg::QAW-1:0]       wr_ptr_r;
  logic [xs_pkg::QAW-1:0]       rd_ptr_r;
  logic [xs_pkg::QCW-1:0]       count_r;
  logic [63:0]                  lo64;
  logic [63:0]                  hi64;
  logic [63:0]                  span;
  xs_pkg::xs_cmd_t              new_cmd;
  logic                         enq;

  assign full      = (count_r == xs_pkg::QCW'(xs_pkg::QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // span is formed on the sign-extended bounds, 64-bit wrap
  assign lo64 = {{32{range_low[31]}}, range_low};
  assign hi64 = {{32{range_high[31]}}, range_high};
  assign span = hi64 - lo64 + 64'd1;

  always_comb begin
    new_cmd.action    = xs_pkg::xs_action_t'(action);
    new_cmd.seed      = seed_value;
    new_cmd.lo        = range_low;
    new_cmd.span      = span;
    new_cmd.span_zero = (span == 64'd0);
  end

  // unused action code is dropped here
  assign enq = push && !full && (new_cmd.action != xs_pkg::ACT_NONE);

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({enq, cmd_take})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= xs_pkg::QCW'(xs_pkg::QDEPTH))
    else $error("command queue over depth");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> count_r != '0)
    else $error("command taken from empty queue");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (enq && !cmd_take) |=> count_r == $past(count_r) + 1'b1)
    else $error("queued word lost");
`endif

endmodule

// ----- hdl/xs_back.sv -----
module xs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  xs_pkg::xs_cmd_t    cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        raw_value,
  output logic signed [31:0] range_value,
  output logic               range_error
);

  xs_pkg::xs_state_t      state_r;
  xs_pkg::xs_state_t      state_nxt;
  xs_pkg::xs_cmd_t        cmd_r;
  logic [63:0]            w_r [xs_pkg::NWORDS];
  logic [63:0]            seed_r;
  logic [63:0]            z_r;
  logic [63:0]            acc_r;
  logic [63:0]            prod_r;
  logic                   mulsel_r;
  logic [1:0]             mcnt_r;
  logic [xs_pkg::WIW-1:0] widx_r;
  logic [63:0]            t5_r;
  logic [63:0]            raw_r;
  logic [63:0]            div_r;
  logic [63:0]            rem_r;
  logic [xs_pkg::BCW-1:0] bcnt_r;
  logic                   out_valid_r;
  logic [63:0]            out_raw_r;
  logic [31:0]            out_rv_r;
  logic                   out_err_r;

  logic [63:0] seed_sum;
  logic [63:0] mconst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mac;
  logic [63:0] w1x5;
  logic [63:0] rot7;
  logic [63:0] scr;
  logic [63:0] n0;
  logic [63:0] n1;
  logic [63:0] n2;
  logic [63:0] n3;
  logic [64:0] div_sh;
  logic [65:0] div_diff;
  logic        out_free;
  logic        out_load;
  logic        is_range;
  logic [31:0] rv_nxt;

  assign seed_sum = seed_r + xs_pkg::SM_GAMMA;
  assign mconst   = mulsel_r ? xs_pkg::SM_MUL2 : xs_pkg::SM_MUL1;
  assign mul_a    = (mcnt_r == 2'd1) ? z_r[63:32] : z_r[31:0];
  assign mul_b    = (mcnt_r == 2'd2) ? mconst[63:32] : mconst[31:0];
  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign mac      = acc_r + {prod_r[31:0], 32'b0};

  assign w1x5 = w_r[1] + {w_r[1][61:0], 2'b0};
  assign rot7 = {w1x5[56:0], w1x5[63:57]};
  assign scr  = t5_r + {t5_r[60:0], 3'b0};

  assign n2 = w_r[2] ^ w_r[0];
  assign n3 = w_r[3] ^ w_r[1];
  assign n1 = w_r[1] ^ n2;
  assign n0 = w_r[0] ^ n3;

  assign div_sh   = {rem_r, div_r[63]};
  assign div_diff = {1'b0, div_sh} - {2'b0, cmd_r.span};

  assign out_free = !out_valid_r || pop;
  assign is_range = (cmd_r.action == xs_pkg::ACT_RANGE);
  assign rv_nxt   = !is_range ? 32'd0 :
                    cmd_r.span_zero ? cmd_r.lo : cmd_r.lo + rem_r[31:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xs_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            xs_pkg::ACT_SEED:                   state_nxt = xs_pkg::ST_SM_ADD;
            xs_pkg::ACT_RAW, xs_pkg::ACT_RANGE: state_nxt = xs_pkg::ST_STEP;
            default:                            state_nxt = xs_pkg::ST_IDLE;
          endcase
        end
      end
      xs_pkg::ST_SM_ADD: state_nxt = xs_pkg::ST_MUL;
      xs_pkg::ST_MUL: begin
        if (mcnt_r == 2'd3 && mulsel_r) begin
          state_nxt = (widx_r == xs_pkg::WIW'(xs_pkg::NWORDS - 1)) ? xs_pkg::ST_IDLE
                                                                    : xs_pkg::ST_SM_ADD;
        end
      end
      xs_pkg::ST_STEP: state_nxt = xs_pkg::ST_SCRAMBLE;
      xs_pkg::ST_SCRAMBLE: begin
        state_nxt = (is_range && !cmd_r.span_zero) ? xs_pkg::ST_DIV : xs_pkg::ST_DONE;
      end
      xs_pkg::ST_DIV: begin
        if (bcnt_r == '0) begin
          state_nxt = xs_pkg::ST_DONE;
        end
      end
      xs_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = xs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = xs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state_r == xs_pkg::ST_IDLE) && cmd_valid;
    out_load = (state_r == xs_pkg::ST_DONE) && out_free;
  end

  // reset runs the seeding sequence for the default seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xs_pkg::ST_SM_ADD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seed_r      <= xs_pkg::RESET_SEED;
      widx_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_raw_r   <= raw_r;
        out_rv_r    <= rv_nxt;
        out_err_r   <= is_range && cmd_r.span_zero;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        xs_pkg::ST_IDLE: begin
          if (cmd_take) begin
            cmd_r  <= cmd;
            seed_r <= cmd.seed;
            widx_r <= '0;
          end
        end
        xs_pkg::ST_SM_ADD: begin
          seed_r   <= seed_sum;
          z_r      <= seed_sum ^ (seed_sum >> 30);
          mcnt_r   <= 2'd0;
          mulsel_r <= 1'b0;
        end
        xs_pkg::ST_MUL: begin
          // low 64 bits of z * const from three 32x32 partial products
          prod_r <= mul_p;
          mcnt_r <= mcnt_r + 2'd1;
          case (mcnt_r)
            2'd1: acc_r <= prod_r;
            2'd2: acc_r <= mac;
            2'd3: begin
              if (!mulsel_r) begin
                z_r      <= mac ^ (mac >> 27);
                mulsel_r <= 1'b1;
              end else begin
                w_r[widx_r] <= mac ^ (mac >> 31);
                widx_r      <= widx_r + 1'b1;
              end
            end
            default: acc_r <= acc_r;
          endcase
        end
        xs_pkg::ST_STEP: begin
          t5_r   <= rot7;
          w_r[0] <= n0;
          w_r[1] <= n1;
          w_r[2] <= n2 ^ {w_r[1][46:0], 17'b0};
          w_r[3] <= {n3[18:0], n3[63:19]};
        end
        xs_pkg::ST_SCRAMBLE: begin
          raw_r  <= scr;
          div_r  <= scr;
          rem_r  <= '0;
          bcnt_r <= xs_pkg::BCW'(xs_pkg::BITS - 1);
        end
        xs_pkg::ST_DIV: begin
          // restoring remainder, one dividend bit per cycle
          rem_r  <= div_diff[65] ? div_sh[63:0] : div_diff[63:0];
          div_r  <= {div_r[62:0], 1'b0};
          bcnt_r <= bcnt_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign empty       = !out_valid_r;
  assign raw_value   = out_raw_r;
  assign range_value = out_rv_r;
  assign range_error = out_err_r;

`ifndef NO_ASSERTIONS
  a_div_ranged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == xs_pkg::ST_DIV |-> is_range && !cmd_r.span_zero && rem_r < cmd_r.span)
    else $error("remainder out of range during divide");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xs_pkg::ST_DIV && bcnt_r == '0) |=>
      state_r == xs_pkg::ST_DONE && rem_r < cmd_r.span)
    else $error("divide did not finish cleanly");
`endif

endmodule

// ----- hdl/xoshiro256ss_generator_unit.sv -----
// xoshiro256** generator with splitmix64 seeding, queue-style ports on both
// sides. A reseed word runs four splitmix64 steps in the back end (each one
// add plus two 64-bit multiplies built from three 32x32 partial products on
// one shared multiplier) and gives no result. A raw word steps the state and
// scrambles it; a ranged word also runs the bit-serial 64-bit remainder (one
// dividend bit per cycle). A zero span skips the divide. After reset the back
// end first seeds with 42; words pushed meanwhile wait in the two-entry
// command queue. Action 3 is accepted and dropped. The result register lets
// the next word proceed while a result waits to be popped.
module xoshiro256ss_generator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_action,
  input  logic [63:0]        in_seed_value,
  input  logic signed [31:0] in_range_low,
  input  logic signed [31:0] in_range_high,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        out_raw_value,
  output logic signed [31:0] out_range_value,
  output logic               out_range_error
);

  xs_pkg::xs_cmd_t cmd;
  logic            cmd_valid;
  logic            cmd_take;

  xs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .action     (in_action),
    .seed_value (in_seed_value),
    .range_low  (in_range_low),
    .range_high (in_range_high),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take)
  );

  xs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .raw_value   (out_raw_value),
    .range_value (out_range_value),
    .range_error (out_range_error)
  );

endmodule
